FILE: rtl/stereo_linear_upsampler_x16_defines.svh
// assertion macros for the stereo linear upsampler
`ifndef STEREO_LINEAR_UPSAMPLER_X16_DEFINES_SVH
`define STEREO_LINEAR_UPSAMPLER_X16_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define SLU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define SLU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SLU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SLU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/slu_pkg.sv
// shared types and constants of the stereo linear upsampler
package slu_pkg;

	localparam int SAMPLE_W = 16;
	localparam int UPSAMPLE_FACTOR_DEF = 16;
	localparam int SAMPLE_MAX = 32767;
	localparam int SAMPLE_MIN = -32768;

	// per-transaction control from the sequencer to both lanes
	typedef struct packed {
		logic load;
		logic use_prev;
		logic step;
		logic zero_step;
	} slu_lane_ctl_t;

	// one generated output frame
	typedef struct packed {
		logic fire;
		logic run_last;
		logic block_done;
	} slu_emit_t;

endpackage

FILE: rtl/slu_in_if.sv
// input frame channel
interface slu_in_if import slu_pkg::*;;
	logic valid;
	logic ready;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic block_end;

	modport source (output valid, output left_sample, output right_sample, output block_end,
		input ready);
	modport sink (input valid, input left_sample, input right_sample, input block_end,
		output ready);
endinterface

FILE: rtl/slu_out_if.sv
// output frame channel
interface slu_out_if import slu_pkg::*;;
	logic valid;
	logic ready;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;
	logic run_last;
	logic block_done;

	modport source (output valid, output left_out, output right_out, output run_last,
		output block_done, input ready);
	modport sink (input valid, input left_out, input right_out, input run_last,
		input block_done, output ready);
endinterface

FILE: rtl/slu_lane.sv
// one channel: held sample, interpolation accumulator, divide and saturate
module slu_lane import slu_pkg::*; #(
	parameter int UPSAMPLE_FACTOR = UPSAMPLE_FACTOR_DEF
) (
	input  logic                       clk,
	input  slu_lane_ctl_t              ctl,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic signed [SAMPLE_W-1:0] value
);

	localparam int PH_BITS = $clog2(UPSAMPLE_FACTOR);
	localparam int NUM_W = SAMPLE_W + 1 + PH_BITS;
	localparam int DIFF_W = SAMPLE_W + 1;
	localparam int SHIFT = NUM_W + PH_BITS;
	localparam int RECIP_W = SHIFT - PH_BITS + 1;
	localparam longint RECIP_VAL =
		((longint'(1) << SHIFT) + longint'(UPSAMPLE_FACTOR) - 1) / longint'(UPSAMPLE_FACTOR);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
	localparam logic signed [NUM_W-1:0] FACTOR_S = NUM_W'(UPSAMPLE_FACTOR);
	localparam int PROD_W = NUM_W + RECIP_W;
	localparam int QUO_W = SAMPLE_W + 1;
	localparam int SAT_W = QUO_W + 1;
	localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(SAMPLE_MAX);
	localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(SAMPLE_MIN);

	logic signed [SAMPLE_W-1:0] prev_q;
	logic signed [NUM_W-1:0]    acc_q;
	logic signed [DIFF_W-1:0]   step_q;

	logic signed [SAMPLE_W-1:0] base;
	logic signed [NUM_W-1:0]    base_ext;
	logic signed [NUM_W-1:0]    start;
	logic signed [DIFF_W-1:0]   diff;
	logic                       neg;
	logic [NUM_W-1:0]           mag;
	logic [PROD_W-1:0]          prod;
	logic [QUO_W-1:0]           quo;
	logic signed [SAT_W-1:0]    res;

	// start of the run: factor times the start sample, slope is the sample step
	assign base = ctl.use_prev ? prev_q : sample;
	assign base_ext = NUM_W'(base);
	assign start = base_ext * FACTOR_S;
	assign diff = DIFF_W'(sample) - DIFF_W'(base);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			prev_q <= sample;
			acc_q <= start;
			step_q <= diff;
		end else if (ctl.step) begin
			acc_q <= acc_q + NUM_W'(step_q);
			if (ctl.zero_step) begin
				step_q <= '0;
			end
		end
	end

	// truncating divide by the factor via exact reciprocal on the magnitude
	assign neg = acc_q[NUM_W-1];
	assign mag = neg ? $unsigned(-acc_q) : $unsigned(acc_q);
	assign prod = PROD_W'(mag) * PROD_W'(RECIP);
	assign quo = prod[SHIFT +: QUO_W];
	assign res = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

	always_comb begin
		if (res > SAT_HI) begin
			value = SAT_HI[SAMPLE_W-1:0];
		end else if (res < SAT_LO) begin
			value = SAT_LO[SAMPLE_W-1:0];
		end else begin
			value = res[SAMPLE_W-1:0];
		end
	end

endmodule

FILE: rtl/slu_seq.sv
// phase sequencer: block state, run phases, input ready and output strobes
`include "stereo_linear_upsampler_x16_defines.svh"

module slu_seq import slu_pkg::*; #(
	parameter int UPSAMPLE_FACTOR = UPSAMPLE_FACTOR_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          block_end,
	input  logic          out_adv,
	output logic          in_ready,
	output slu_lane_ctl_t lane_ctl,
	output slu_emit_t     emit
);

	localparam int PH_BITS = $clog2(UPSAMPLE_FACTOR);
	localparam logic [PH_BITS-1:0] LAST_PHASE = PH_BITS'(UPSAMPLE_FACTOR - 1);

	logic               busy_q;
	logic               interp_q;
	logic               end_q;
	logic               prev_valid_q;
	logic [PH_BITS-1:0] phase_q;

	logic fire;
	logic at_last_phase;
	logic to_copy;
	logic final_step;
	logic load;

	assign fire = busy_q && out_adv;
	assign at_last_phase = (phase_q == LAST_PHASE);
	// interpolation run of a block-ending frame continues with the copy run
	assign to_copy = at_last_phase && interp_q && end_q;
	assign final_step = at_last_phase && !(interp_q && end_q);
	assign in_ready = !busy_q || (fire && final_step);
	assign load = in_valid && in_ready;

	always_comb begin
		lane_ctl.load = load;
		lane_ctl.use_prev = prev_valid_q;
		lane_ctl.step = fire;
		lane_ctl.zero_step = to_copy;
		emit.fire = fire;
		emit.run_last = final_step;
		emit.block_done = final_step && end_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			interp_q <= 1'b0;
			end_q <= 1'b0;
			prev_valid_q <= 1'b0;
			phase_q <= '0;
		end else if (load) begin
			busy_q <= prev_valid_q || block_end;
			interp_q <= prev_valid_q;
			end_q <= block_end;
			prev_valid_q <= !block_end;
			phase_q <= '0;
		end else if (fire) begin
			if (at_last_phase) begin
				phase_q <= '0;
				if (to_copy) begin
					interp_q <= 1'b0;
				end else begin
					busy_q <= 1'b0;
				end
			end else begin
				phase_q <= phase_q + 1'b1;
			end
		end
	end

	`SLU_ASSERT_NEXT(a_end_closes_block, clk, arst_n, load && block_end, !prev_valid_q && busy_q, "block end did not close the block")
	`SLU_ASSERT_NEXT(a_first_frame_silent, clk, arst_n, load && !prev_valid_q && !block_end, !busy_q, "first frame of a block started a run")
	`SLU_ASSERT_NEXT(a_copy_follows_interp, clk, arst_n, fire && to_copy, busy_q && !interp_q && phase_q == '0, "copy run did not follow interpolation")
	`SLU_ASSERT_NOW(a_done_is_last, clk, arst_n, emit.fire && emit.block_done, emit.run_last, "block done without run last")

endmodule

FILE: rtl/stereo_linear_upsampler_x16.sv
// top level of the stereo linear upsampler
//
// channel   modport  payload                                      transaction
// frames    sink     left_sample, right_sample, block_end         one stereo input frame
// results   source   left_out, right_out, run_last, block_done    one upsampled frame
//
// one output frame per cycle while results is not stalled; a frame inside a block gives
// UPSAMPLE_FACTOR outputs, a block-ending frame 2*UPSAMPLE_FACTOR (UPSAMPLE_FACTOR if it is
// the only one), and the first frame of a block is taken with no output
// the rate is set by the phase sequencer, which steps both lane accumulators once per frame out
// frames is ready again in the cycle that produces the last output of the current frame
// arst_n clears the sequencer and the output valid; a results stall holds the run and output
`include "stereo_linear_upsampler_x16_defines.svh"

module stereo_linear_upsampler_x16 import slu_pkg::*; #(
	parameter int UPSAMPLE_FACTOR = UPSAMPLE_FACTOR_DEF
) (
	input logic       clk,
	input logic       arst_n,
	slu_in_if.sink    frames,
	slu_out_if.source results
);

	slu_lane_ctl_t lane_ctl;
	slu_emit_t     emit;

	logic                       out_adv;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;
	logic                       run_last_q;
	logic                       block_done_q;
	logic signed [SAMPLE_W-1:0] left_val;
	logic signed [SAMPLE_W-1:0] right_val;

	// output register can take a new frame when empty or being drained
	assign out_adv = !out_valid_q || results.ready;

	slu_seq #(
		.UPSAMPLE_FACTOR(UPSAMPLE_FACTOR)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frames.valid),
		.block_end(frames.block_end),
		.out_adv  (out_adv),
		.in_ready (frames.ready),
		.lane_ctl (lane_ctl),
		.emit     (emit)
	);

	// left lane
	slu_lane #(
		.UPSAMPLE_FACTOR(UPSAMPLE_FACTOR)
	) u_lane_left (
		.clk   (clk),
		.ctl   (lane_ctl),
		.sample(frames.left_sample),
		.value (left_val)
	);

	// right lane
	slu_lane #(
		.UPSAMPLE_FACTOR(UPSAMPLE_FACTOR)
	) u_lane_right (
		.clk   (clk),
		.ctl   (lane_ctl),
		.sample(frames.right_sample),
		.value (right_val)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.fire) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit.fire) begin
			left_q <= left_val;
			right_q <= right_val;
			run_last_q <= emit.run_last;
			block_done_q <= emit.block_done;
		end
	end

	assign results.valid = out_valid_q;
	assign results.left_out = left_q;
	assign results.right_out = right_q;
	assign results.run_last = run_last_q;
	assign results.block_done = block_done_q;

	`SLU_ASSERT_NEXT(a_stall_holds_frame, clk, arst_n, out_valid_q && !results.ready, out_valid_q && $stable(left_q) && $stable(right_q), "stalled result changed")
	`SLU_ASSERT_NOW(a_fire_needs_room, clk, arst_n, emit.fire, out_adv, "frame generated into a full output register")
	`SLU_ASSERT_NOW(a_accept_only_on_last, clk, arst_n, frames.valid && frames.ready && emit.fire, emit.run_last, "frame taken before the run ended")

endmodule

FILE: sim/testbench.sv
// self-checking testbench for stereo_linear_upsampler_x16: random frame blocks, gaps and stalls
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import slu_pkg::*;

	localparam int FACTOR       = UPSAMPLE_FACTOR_DEF;
	localparam int RANDOM_ITEMS = 480;
	localparam int WATCHDOG     = 400000;
	localparam int MAX_PRINTS   = 30;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// one stereo input frame as the sender drives it
	typedef struct {
		sample_t left;
		sample_t right;
		logic    block_end;
	} stereo_frame_t;

	// one upsampled output frame as the receiver should see it
	typedef struct {
		sample_t left;
		sample_t right;
		logic    run_last;
		logic    block_done;
	} upframe_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_FREE,
		RX_CHOPPY,
		RX_THROTTLED
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	slu_in_if  frames_if ();
	slu_out_if results_if ();

	stereo_linear_upsampler_x16 i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.frames  (frames_if.sink),
		.results (results_if.source)
	);

	// pending input frames and the upsampled frames still owed by the block
	stereo_frame_t frame_q[$];
	upframe_t      upsampled_q[$];

	// interpolation history, mirrors the block's previous-frame registers
	sample_t hist_left = '0;
	sample_t hist_right = '0;
	logic    hist_valid = 1'b0;

	int frames_total;
	int frames_taken = 0;
	int results_seen = 0;
	int blocks_closed = 0;
	int mismatches = 0;

	// sender burst shaping
	int burst_left = 4;
	int gap_left = 0;

	// receiver stall shaping
	rx_mode_t rx_mode = RX_FREE;
	int       rx_left = 40;
	int       rx_phase = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// linear blend of two samples at one phase, truncated toward zero and clipped
	function automatic sample_t blend(sample_t a, sample_t b, int phase);
		int num;
		int q;
		num = (FACTOR - phase) * int'(a) + phase * int'(b);
		q = num / FACTOR;
		if (q > SAMPLE_MAX)
			q = SAMPLE_MAX;
		else if (q < SAMPLE_MIN)
			q = SAMPLE_MIN;
		return sample_t'(q);
	endfunction

	// queues every output frame that one accepted input frame causes
	task automatic interpolate_frame(sample_t cur_l, sample_t cur_r, logic ends_block);
		upframe_t uf;
		int first_new;
		first_new = upsampled_q.size();
		// interpolation run from the held frame toward this one
		if (hist_valid) begin
			for (int p = 0; p < FACTOR; p++) begin
				uf.left = blend(hist_left, cur_l, p);
				uf.right = blend(hist_right, cur_r, p);
				uf.run_last = 1'b0;
				uf.block_done = 1'b0;
				upsampled_q.push_back(uf);
			end
		end
		// a closing frame repeats itself and flags the last copy
		if (ends_block) begin
			for (int p = 0; p < FACTOR; p++) begin
				uf.left = cur_l;
				uf.right = cur_r;
				uf.run_last = 1'b0;
				uf.block_done = (p == FACTOR - 1);
				upsampled_q.push_back(uf);
			end
			hist_left = '0;
			hist_right = '0;
			hist_valid = 1'b0;
		end else begin
			hist_left = cur_l;
			hist_right = cur_r;
			hist_valid = 1'b1;
		end
		if (upsampled_q.size() > first_new)
			upsampled_q[upsampled_q.size() - 1].run_last = 1'b1;
	endtask

	task automatic report_mismatch(string field, int got, int want);
		if (mismatches < MAX_PRINTS)
			$display("%0t mismatch on %s after %0d output frames: got %0d, want %0d",
				$realtime, field, results_seen, got, want);
		mismatches++;
	endtask

	task automatic queue_frame(int l, int r, logic e);
		stereo_frame_t f;
		f.left = sample_t'(l);
		f.right = sample_t'(r);
		f.block_end = e;
		frame_q.push_back(f);
	endtask

	// sample source weighted toward the rails and toward zero
	function automatic int pick_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2, 3: return $urandom_range(0, 40) - 20;
			default: return int'(sample_t'($urandom_range(0, 65535)));
		endcase
	endfunction

	// sender: bursts of frames with random gaps in between
	always @(posedge clk or negedge arst_n) begin
		stereo_frame_t nxt;
		if (!arst_n) begin
			frames_if.valid <= 1'b0;
			frames_if.left_sample <= '0;
			frames_if.right_sample <= '0;
			frames_if.block_end <= 1'b0;
		end else if (!frames_if.valid || frames_if.ready) begin
			if (gap_left > 0 || frame_q.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				frames_if.valid <= 1'b0;
			end else begin
				nxt = frame_q.pop_front();
				frames_if.valid <= 1'b1;
				frames_if.left_sample <= nxt.left;
				frames_if.right_sample <= nxt.right;
				frames_if.block_end <= nxt.block_end;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// new burst; a quarter of the bursts follow on with no gap at all
					burst_left = $urandom_range(1, 12);
					case ($urandom_range(0, 3))
						0: gap_left = 0;
						1: gap_left = $urandom_range(1, 5);
						2: gap_left = $urandom_range(6, 20);
						default: gap_left = $urandom_range(21, 50);
					endcase
				end
			end
		end
	end

	// receiver: segments of free flow, random chop and a fixed throttle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				rx_left = $urandom_range(16, 160);
				rx_phase = 0;
			end else begin
				rx_left--;
			end
			rx_phase++;
			case (rx_mode)
				RX_FREE: results_if.ready <= 1'b1;
				RX_CHOPPY: results_if.ready <= ($urandom_range(0, 3) != 0);
				default: results_if.ready <= (rx_phase % 5 == 0);
			endcase
		end
	end

	// monitor: predicts on every input transaction, checks every output transaction
	always @(posedge clk) begin
		upframe_t want;
		if (arst_n) begin
			if (frames_if.valid && frames_if.ready) begin
				interpolate_frame(frames_if.left_sample, frames_if.right_sample,
					frames_if.block_end);
				frames_taken++;
			end
			if (results_if.valid && results_if.ready) begin
				if (upsampled_q.size() == 0) begin
					report_mismatch("unexpected output frame", results_if.left_out, 0);
				end else begin
					want = upsampled_q.pop_front();
					if (results_if.left_out !== want.left)
						report_mismatch("left_out", results_if.left_out, want.left);
					if (results_if.right_out !== want.right)
						report_mismatch("right_out", results_if.right_out, want.right);
					if (results_if.run_last !== want.run_last)
						report_mismatch("run_last", results_if.run_last, want.run_last);
					if (results_if.block_done !== want.block_done)
						report_mismatch("block_done", results_if.block_done, want.block_done);
				end
				if (results_if.block_done === 1'b1)
					blocks_closed++;
				results_seen++;
			end
		end
	end

	// watchdog, well above the slowest legal run
	initial begin
		repeat (WATCHDOG) @(posedge clk);
		$display("[stereo_linear_upsampler_x16] ERROR");
		$finish;
	end

	initial begin
		int blk_len;

		// directed: a block of one frame, only the repeated copies
		queue_frame(1234, -4321, 1'b1);
		// rail to rail swings, then a closing frame at full scale (interp run plus copies)
		queue_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
		queue_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
		queue_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
		// small steps around zero, where truncation toward zero matters
		queue_frame(0, 0, 1'b0);
		queue_frame(-1, 1, 1'b0);
		queue_frame(-7, 5, 1'b0);
		queue_frame(3, -9, 1'b0);
		queue_frame(1, -1, 1'b1);
		// negative rail held, and two single-frame blocks back to back
		queue_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
		queue_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
		queue_frame(-1, -1, 1'b1);
		queue_frame(0, 0, 1'b1);
		// first frame of a block after a close is only held
		queue_frame(-32767, 32766, 1'b0);
		queue_frame(16, -16, 1'b0);
		queue_frame(-15, 17, 1'b1);

		// random: well-formed blocks of random length, some single-frame closes among them
		while (frame_q.size() < RANDOM_ITEMS) begin
			blk_len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
			for (int i = 0; i < blk_len; i++)
				queue_frame(pick_sample(), pick_sample(), i == blk_len - 1);
		end
		// a trailing block left open, its last frame stays held
		queue_frame(pick_sample(), pick_sample(), 1'b0);
		queue_frame(pick_sample(), pick_sample(), 1'b0);
		frames_total = frame_q.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (frames_taken < frames_total)
			@(posedge clk);
		while (upsampled_q.size() != 0)
			@(posedge clk);
		// anything late or extra shows up as an unexpected output frame
		repeat (4 * FACTOR) @(posedge clk);

		$display("run covered %0d input frames and %0d output frames, %0d blocks closed",
			frames_taken, results_seen, blocks_closed);
		$display("with sender gaps, receiver stalls and %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("[stereo_linear_upsampler_x16] OK");
		else
			$display("[stereo_linear_upsampler_x16] ERROR");
		$finish;
	end

endmodule
